@@ src/amcf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the audio module command framer.
// Holds payload structs, queue job type, operation and register codes, frame bytes.
package amcf_pkg;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
        logic       last;
    } t_out_item;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_INIT   = 3'd1;
    localparam logic [2:0] OP_PLAY   = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_VOLUME = 3'd4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_GUARD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VOLUME   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_VOLUME  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_DEVICE  = 2'd3;

    localparam logic [15:0] RST_REPEAT_GUARD = 16'd250;
    localparam logic [7:0]  RST_MAX_VOLUME   = 8'd30;
    localparam logic [7:0]  RST_INIT_VOLUME  = 8'd30;
    localparam logic [7:0]  RST_INIT_DEVICE  = 8'd2;

    localparam logic [7:0] FRAME_START = 8'h7E;
    localparam logic [7:0] FRAME_VER   = 8'hFF;
    localparam logic [7:0] FRAME_LEN   = 8'h06;
    localparam logic [7:0] FRAME_PAD   = 8'h00;
    localparam logic [7:0] FRAME_END   = 8'hEF;
    localparam logic [7:0] PARAM_HIGH  = 8'h00;
    localparam logic [7:0] CMD_RESET   = 8'h0C;
    localparam logic [7:0] CMD_SELECT  = 8'h09;
    localparam logic [7:0] CMD_VOLUME  = 8'h06;
    localparam logic [7:0] CMD_STOP    = 8'h16;
    localparam logic [7:0] CMD_PLAY    = 8'h03;
    localparam logic [7:0] NO_TRACK    = 8'hFF;

    localparam logic [3:0] BYTE_LAST = 4'd9;

    typedef enum logic [2:0] {
        JOB_INIT,
        JOB_PLAY,
        JOB_STOP_PLAY,
        JOB_STOP,
        JOB_VOLUME
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] p0;
        logic [7:0] p1;
    } t_job;

endpackage

@@ src/amcf_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts command words, keeps player state and config registers,
// and queues frame jobs. Depends on amcf_pkg.
module amcf_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  amcf_pkg::t_in_item                 i_in,
    input  logic                               i_q_full,
    output logic                               o_accept,
    output logic                               o_push,
    output amcf_pkg::t_job                     o_job,
    input  logic                               i_cfg_valid,
    input  logic [amcf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [amcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [15:0] r_guard;
    logic [7:0]  r_max_vol;
    logic [7:0]  r_init_vol;
    logic [7:0]  r_init_dev;
    logic        r_ready, n_ready;
    logic [7:0]  r_track, n_track;
    logic [31:0] r_play_time, n_play_time;
    logic [31:0] r_now, n_now;
    logic [31:0] elapsed;
    logic        repeat_hit;
    logic [7:0]  vol_clamped;

    assign o_accept    = i_in_valid && !i_q_full;
    assign elapsed     = r_now - r_play_time;
    assign repeat_hit  = (i_in.value == r_track) && (elapsed < {16'd0, r_guard});
    assign vol_clamped = (i_in.value > r_max_vol) ? r_max_vol : i_in.value;

    always_comb begin
        n_ready     = r_ready;
        n_track     = r_track;
        n_play_time = r_play_time;
        n_now       = r_now;
        o_push      = 1'b0;
        o_job.kind  = amcf_pkg::JOB_STOP;
        o_job.p0    = i_in.value;
        o_job.p1    = r_init_vol;
        if (o_accept) begin
            case (i_in.operation)
                amcf_pkg::OP_TICK: begin
                    n_now = r_now + 32'd1;
                end
                amcf_pkg::OP_INIT: begin
                    o_push      = 1'b1;
                    o_job.kind  = amcf_pkg::JOB_INIT;
                    o_job.p0    = r_init_dev;
                    n_ready     = 1'b1;
                    n_track     = amcf_pkg::NO_TRACK;
                    n_play_time = 32'd0;
                end
                amcf_pkg::OP_PLAY: begin
                    if (r_ready && (i_in.value != 8'd0) && !repeat_hit) begin
                        o_push      = 1'b1;
                        o_job.kind  = (r_track != amcf_pkg::NO_TRACK) ?
                                      amcf_pkg::JOB_STOP_PLAY : amcf_pkg::JOB_PLAY;
                        n_track     = i_in.value;
                        n_play_time = r_now;
                    end
                end
                amcf_pkg::OP_STOP: begin
                    if (r_ready) begin
                        o_push     = 1'b1;
                        o_job.kind = amcf_pkg::JOB_STOP;
                        n_track    = amcf_pkg::NO_TRACK;
                    end
                end
                amcf_pkg::OP_VOLUME: begin
                    if (r_ready) begin
                        o_push     = 1'b1;
                        o_job.kind = amcf_pkg::JOB_VOLUME;
                        o_job.p0   = vol_clamped;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_track     <= amcf_pkg::NO_TRACK;
            r_play_time <= 32'd0;
            r_now       <= 32'd0;
            r_guard     <= amcf_pkg::RST_REPEAT_GUARD;
            r_max_vol   <= amcf_pkg::RST_MAX_VOLUME;
            r_init_vol  <= amcf_pkg::RST_INIT_VOLUME;
            r_init_dev  <= amcf_pkg::RST_INIT_DEVICE;
        end else begin
            r_ready     <= n_ready;
            r_track     <= n_track;
            r_play_time <= n_play_time;
            r_now       <= n_now;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    amcf_pkg::CFG_REPEAT_GUARD: r_guard    <= i_cfg_data;
                    amcf_pkg::CFG_MAX_VOLUME:   r_max_vol  <= i_cfg_data[7:0];
                    amcf_pkg::CFG_INIT_VOLUME:  r_init_vol <= i_cfg_data[7:0];
                    amcf_pkg::CFG_INIT_DEVICE:  r_init_dev <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ src/amcf_queue.sv @@
`timescale 1ns / 1ps
// Job queue between front end and serializer.
// Small register FIFO of amcf_pkg::t_job entries.
module amcf_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  amcf_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output amcf_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    amcf_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_MAX) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_MAX) ? '0 : r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/amcf_back.sv @@
`timescale 1ns / 1ps
// Serializer: turns queued jobs into checksummed 10-byte frames, one
// word per unstalled cycle into an output register. Uses amcf_pkg.
module amcf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  amcf_pkg::t_job      i_q_job,
    output logic                o_pop,
    output logic                o_out_valid,
    output amcf_pkg::t_out_item o_out,
    input  logic                i_out_stall
);

    logic                r_busy, n_busy;
    amcf_pkg::t_job      r_job;
    logic [1:0]          r_frame, n_frame;
    logic [3:0]          r_byte, n_byte;
    logic                r_out_valid;
    amcf_pkg::t_out_item r_out;
    logic                emit;
    logic [1:0]          frame_last;
    logic [7:0]          cmd, param_lo;
    logic [15:0]         sum, ck;
    logic [7:0]          cur_byte;
    logic                job_done;

    assign emit     = r_busy && (!r_out_valid || !i_out_stall);
    assign job_done = (r_frame == frame_last) && (r_byte == amcf_pkg::BYTE_LAST);
    assign o_pop    = i_q_valid && (!r_busy || (emit && job_done));

    always_comb begin
        frame_last = 2'd0;
        cmd        = amcf_pkg::CMD_STOP;
        param_lo   = 8'd0;
        case (r_job.kind)
            amcf_pkg::JOB_INIT: begin
                frame_last = 2'd3;
                case (r_frame)
                    2'd0:    cmd = amcf_pkg::CMD_RESET;
                    2'd1: begin
                        cmd      = amcf_pkg::CMD_SELECT;
                        param_lo = r_job.p0;
                    end
                    2'd2: begin
                        cmd      = amcf_pkg::CMD_VOLUME;
                        param_lo = r_job.p1;
                    end
                    default: cmd = amcf_pkg::CMD_STOP;
                endcase
            end
            amcf_pkg::JOB_STOP_PLAY: begin
                frame_last = 2'd1;
                if (r_frame != 2'd0) begin
                    cmd      = amcf_pkg::CMD_PLAY;
                    param_lo = r_job.p0;
                end
            end
            amcf_pkg::JOB_PLAY: begin
                cmd      = amcf_pkg::CMD_PLAY;
                param_lo = r_job.p0;
            end
            amcf_pkg::JOB_VOLUME: begin
                cmd      = amcf_pkg::CMD_VOLUME;
                param_lo = r_job.p0;
            end
            default: begin
            end
        endcase
    end

    assign sum = {8'd0, amcf_pkg::FRAME_VER} + {8'd0, amcf_pkg::FRAME_LEN} + {8'd0, cmd}
               + {8'd0, amcf_pkg::PARAM_HIGH} + {8'd0, param_lo};
    assign ck  = 16'd0 - sum;

    always_comb begin
        case (r_byte)
            4'd0:    cur_byte = amcf_pkg::FRAME_START;
            4'd1:    cur_byte = amcf_pkg::FRAME_VER;
            4'd2:    cur_byte = amcf_pkg::FRAME_LEN;
            4'd3:    cur_byte = cmd;
            4'd4:    cur_byte = amcf_pkg::FRAME_PAD;
            4'd5:    cur_byte = amcf_pkg::PARAM_HIGH;
            4'd6:    cur_byte = param_lo;
            4'd7:    cur_byte = ck[15:8];
            4'd8:    cur_byte = ck[7:0];
            default: cur_byte = amcf_pkg::FRAME_END;
        endcase
    end

    always_comb begin
        n_busy  = r_busy;
        n_frame = r_frame;
        n_byte  = r_byte;
        if (emit) begin
            if (r_byte == amcf_pkg::BYTE_LAST) begin
                n_byte  = 4'd0;
                n_frame = r_frame + 2'd1;
            end else begin
                n_byte = r_byte + 4'd1;
            end
            if (job_done) begin
                n_busy  = 1'b0;
                n_frame = 2'd0;
            end
        end
        if (o_pop) begin
            n_busy  = 1'b1;
            n_frame = 2'd0;
            n_byte  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_out.frame_byte   <= cur_byte;
            r_out.end_of_frame <= (r_byte == amcf_pkg::BYTE_LAST);
            r_out.last         <= job_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_frame     <= 2'd0;
            r_byte      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_frame <= n_frame;
            r_byte  <= n_byte;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ src/audio_module_command_framer.sv @@
`timescale 1ns / 1ps
// Top level of the audio module command framer: front end, job queue, serializer.
// Depends on amcf_pkg, amcf_front, amcf_queue, amcf_back.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-----------------------------------
//  in       | i_in_valid / o_in_stall       | i_in  (operation, value)
//  out      | o_out_valid / i_out_stall     | o_out (frame_byte, end_of_frame, last)
//  cfg      | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A command word is taken whenever the job queue has room; ticks and ignored
// commands queue no job. The serializer emits one word per cycle unless the
// output stalls, 10 words per frame: 4 frames for init, 2 for a play while a
// track is recorded, 1 for any other frame command.
// Reset is synchronous, active low. Output stall holds the output register and
// the serializer; input stall rises only when the queue is full.
module audio_module_command_framer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  amcf_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output amcf_pkg::t_out_item               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [amcf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [amcf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic           q_full, q_valid, q_pop, f_push, f_accept;
    amcf_pkg::t_job f_job, q_job;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    amcf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_accept    (f_accept),
        .o_push      (f_push),
        .o_job       (f_job),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    amcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push && f_accept),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    amcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule
